[hdl/ksub_pkg.sv]
// Shared types, constants and helpers for the Koch segment subdivider.
`timescale 1ns / 1ps

package ksub_pkg;

    // Coordinate format: signed Q4.14.
    localparam int COORD_W = 18;
    localparam int LEVEL_W = 2;

    // Traversal stack: three pending siblings per open level.
    localparam int MAX_DEPTH   = 3;
    localparam int STACK_DEPTH = 3 * MAX_DEPTH;
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);
    localparam int STACK_IDX_W = $clog2(STACK_DEPTH);

    // Multiplier operand and product widths.
    localparam int MUL_W  = 21;
    localparam int PROD_W = 2 * MUL_W;

    // Floor division by three: bias to a nonnegative value, multiply by the
    // rounded-up reciprocal, shift, and remove the bias again.
    localparam int                     DIV3_SHIFT = 21;
    localparam logic signed [MUL_W-1:0] DIV3_M    = 21'sd699051;
    localparam logic signed [20:0]     DIV3_BIAS  = 21'sd786432;
    localparam logic signed [19:0]     DIV3_UNBIAS = 20'sd262144;

    // Peak offset scale sqrt(3)/6 in Q0.16, and its rounding constant.
    localparam logic signed [MUL_W-1:0]  PEAK_K     = 21'sd18919;
    localparam logic signed [PROD_W-1:0] PEAK_ROUND = 42'sd32768;

    localparam logic signed [COORD_W-1:0] COORD_MAX = 18'sh1FFFF;
    localparam logic signed [COORD_W-1:0] COORD_MIN = 18'sh20000;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
    } point_t;

    typedef struct packed {
        point_t a;
        point_t b;
    } seg_t;

    typedef struct packed {
        seg_t              seg;
        logic [LEVEL_W-1:0] lvl;
    } stack_entry_t;

    // Datapath operations issued by the controller, one per cycle.
    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD_IN,
        DP_DIFF,
        DP_MUL_QX,
        DP_MUL_QY,
        DP_MUL_OX,
        DP_MUL_OY,
        DP_VERTEX,
        DP_PUSH_HI,
        DP_PUSH_MID,
        DP_PUSH_LO,
        DP_EMIT
    } dp_op_t;

    // Status returned by the datapath.
    typedef struct packed {
        logic leaf;
        logic stack_empty;
        logic out_free;
    } dp_status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEG,
        ST_MUL_QX,
        ST_MUL_QY,
        ST_MUL_OX,
        ST_MUL_OY,
        ST_POST,
        ST_VERTEX,
        ST_PUSH_HI,
        ST_PUSH_MID,
        ST_PUSH_LO
    } state_t;

    // Clamp a wide intermediate to the coordinate range.
    function automatic coord_t sat_coord(input logic signed [20:0] v);
        coord_t r;
        if (v > 21'(COORD_MAX)) begin
            r = COORD_MAX;
        end else if (v < 21'(COORD_MIN)) begin
            r = COORD_MIN;
        end else begin
            r = v[COORD_W-1:0];
        end
        return r;
    endfunction

endpackage

[hdl/ksub_ctrl.sv]
// Sequencing state machine for the Koch segment subdivider.
`timescale 1ns / 1ps

module ksub_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  ksub_pkg::dp_status_t status,
    output ksub_pkg::dp_op_t     op
);

    ksub_pkg::state_t state_reg;
    ksub_pkg::state_t state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ksub_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state: a segment is either emitted or split into four.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ksub_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ksub_pkg::ST_SEG;
                end
            end
            ksub_pkg::ST_SEG: begin
                if (!status.leaf) begin
                    state_next = ksub_pkg::ST_MUL_QX;
                end else if (status.out_free && status.stack_empty) begin
                    state_next = ksub_pkg::ST_IDLE;
                end
            end
            ksub_pkg::ST_MUL_QX:   state_next = ksub_pkg::ST_MUL_QY;
            ksub_pkg::ST_MUL_QY:   state_next = ksub_pkg::ST_MUL_OX;
            ksub_pkg::ST_MUL_OX:   state_next = ksub_pkg::ST_MUL_OY;
            ksub_pkg::ST_MUL_OY:   state_next = ksub_pkg::ST_POST;
            ksub_pkg::ST_POST:     state_next = ksub_pkg::ST_VERTEX;
            ksub_pkg::ST_VERTEX:   state_next = ksub_pkg::ST_PUSH_HI;
            ksub_pkg::ST_PUSH_HI:  state_next = ksub_pkg::ST_PUSH_MID;
            ksub_pkg::ST_PUSH_MID: state_next = ksub_pkg::ST_PUSH_LO;
            ksub_pkg::ST_PUSH_LO:  state_next = ksub_pkg::ST_SEG;
            default:               state_next = ksub_pkg::ST_IDLE;
        endcase
    end

    // Outputs: one datapath operation per state.
    always_comb begin
        op       = ksub_pkg::DP_NOP;
        s_tready = 1'b0;
        case (state_reg)
            ksub_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    op = ksub_pkg::DP_LOAD_IN;
                end
            end
            ksub_pkg::ST_SEG: begin
                if (!status.leaf) begin
                    op = ksub_pkg::DP_DIFF;
                end else if (status.out_free) begin
                    op = ksub_pkg::DP_EMIT;
                end
            end
            ksub_pkg::ST_MUL_QX:   op = ksub_pkg::DP_MUL_QX;
            ksub_pkg::ST_MUL_QY:   op = ksub_pkg::DP_MUL_QY;
            ksub_pkg::ST_MUL_OX:   op = ksub_pkg::DP_MUL_OX;
            ksub_pkg::ST_MUL_OY:   op = ksub_pkg::DP_MUL_OY;
            ksub_pkg::ST_POST:     op = ksub_pkg::DP_NOP;
            ksub_pkg::ST_VERTEX:   op = ksub_pkg::DP_VERTEX;
            ksub_pkg::ST_PUSH_HI:  op = ksub_pkg::DP_PUSH_HI;
            ksub_pkg::ST_PUSH_MID: op = ksub_pkg::DP_PUSH_MID;
            ksub_pkg::ST_PUSH_LO:  op = ksub_pkg::DP_PUSH_LO;
            default:               op = ksub_pkg::DP_NOP;
        endcase
    end

endmodule

[hdl/ksub_datapath.sv]
// Datapath: current segment, shared multiplier, vertex math, sibling stack, output register.
`timescale 1ns / 1ps

module ksub_datapath (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  ksub_pkg::dp_op_t     op,
    output ksub_pkg::dp_status_t status,
    input  logic                 cfg_wr_en,
    input  logic [1:0]           cfg_wr_data,
    input  logic [71:0]          s_tdata,
    output logic [71:0]          m_tdata,
    output logic                 m_tvalid,
    output logic                 m_tlast,
    input  logic                 m_tready
);

    typedef struct packed {
        ksub_pkg::coord_t v0;
        ksub_pkg::coord_t v1;
        ksub_pkg::coord_t pk;
    } axis_t;

    // New vertices along one axis from the quotient and the peak offset.
    function automatic axis_t split_axis(
        input ksub_pkg::coord_t  a,
        input ksub_pkg::coord_t  b,
        input logic signed [18:0] d,
        input logic signed [18:0] q,
        input ksub_pkg::coord_t  off
    );
        axis_t              r;
        logic signed [20:0] rem;
        logic signed [20:0] bump;
        logic signed [18:0] sum_ab;
        rem    = 21'(d) - 21'(q) - 21'(q) - 21'(q);
        bump   = (rem[1:0] == 2'd2) ? 21'sd1 : 21'sd0;
        sum_ab = 19'(a) + 19'(b);
        r.v0   = ksub_pkg::sat_coord(21'(a) + 21'(q));
        r.v1   = ksub_pkg::sat_coord(21'(a) + 21'(q) + 21'(q) + bump);
        r.pk   = ksub_pkg::sat_coord(21'(signed'(sum_ab[18:1])) + 21'(off));
        return r;
    endfunction

    logic [ksub_pkg::LEVEL_W-1:0]      depth_reg;
    ksub_pkg::seg_t                    cur_reg;
    logic [ksub_pkg::LEVEL_W-1:0]      lvl_reg;
    logic signed [18:0]                dx_reg;
    logic signed [18:0]                dy_reg;
    logic [19:0]                       nx_reg;
    logic [19:0]                       ny_reg;
    logic signed [ksub_pkg::PROD_W-1:0] prod_reg;
    ksub_pkg::dp_op_t                  post_sel_reg;
    logic signed [18:0]                qx_reg;
    logic signed [18:0]                qy_reg;
    ksub_pkg::coord_t                  offx_reg;
    ksub_pkg::coord_t                  offy_reg;
    ksub_pkg::point_t                  v0_reg;
    ksub_pkg::point_t                  v1_reg;
    ksub_pkg::point_t                  pk_reg;
    logic [ksub_pkg::SP_W-1:0]         sp_reg;
    ksub_pkg::stack_entry_t            stack_mem [ksub_pkg::STACK_DEPTH];
    ksub_pkg::seg_t                    out_seg_reg;
    logic                              out_last_reg;
    logic                              out_valid_reg;

    logic signed [18:0]                dx_w;
    logic signed [18:0]                dy_w;
    logic signed [20:0]                nx_w;
    logic signed [20:0]                ny_w;
    logic signed [ksub_pkg::MUL_W-1:0] mul_a;
    logic signed [ksub_pkg::MUL_W-1:0] mul_b;
    logic signed [19:0]                div_q_wide;
    logic signed [ksub_pkg::PROD_W-1:0] rnd_prod;
    axis_t                             ax_x;
    axis_t                             ax_y;
    logic [ksub_pkg::SP_W-1:0]         sp_top;
    logic [ksub_pkg::LEVEL_W-1:0]      lvl_child;

    // Depth register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg <= 2'd3;
        end else if (cfg_wr_en) begin
            depth_reg <= cfg_wr_data;
        end
    end

    // Differences and biased dividends.
    assign dx_w = 19'(cur_reg.b.x) - 19'(cur_reg.a.x);
    assign dy_w = 19'(cur_reg.b.y) - 19'(cur_reg.a.y);
    assign nx_w = 21'(dx_w) + ksub_pkg::DIV3_BIAS;
    assign ny_w = 21'(dy_w) + ksub_pkg::DIV3_BIAS;

    // Shared multiplier operand selection.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (op)
            ksub_pkg::DP_MUL_QX: begin
                mul_a = {1'b0, nx_reg};
                mul_b = ksub_pkg::DIV3_M;
            end
            ksub_pkg::DP_MUL_QY: begin
                mul_a = {1'b0, ny_reg};
                mul_b = ksub_pkg::DIV3_M;
            end
            ksub_pkg::DP_MUL_OX: begin
                mul_a = 21'(dy_reg);
                mul_b = -ksub_pkg::PEAK_K;
            end
            ksub_pkg::DP_MUL_OY: begin
                mul_a = 21'(dx_reg);
                mul_b = ksub_pkg::PEAK_K;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Product post-processing: unbias the quotient, round the offset.
    assign div_q_wide = signed'({1'b0, prod_reg[39:ksub_pkg::DIV3_SHIFT]})
                        - ksub_pkg::DIV3_UNBIAS;
    assign rnd_prod   = prod_reg + ksub_pkg::PEAK_ROUND;

    assign ax_x = split_axis(cur_reg.a.x, cur_reg.b.x, dx_reg, qx_reg, offx_reg);
    assign ax_y = split_axis(cur_reg.a.y, cur_reg.b.y, dy_reg, qy_reg, offy_reg);

    assign sp_top    = sp_reg - 1'b1;
    assign lvl_child = lvl_reg + 1'b1;

    // Arithmetic pipeline registers.
    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        if (op == ksub_pkg::DP_DIFF) begin
            dx_reg <= dx_w;
            dy_reg <= dy_w;
            nx_reg <= nx_w[19:0];
            ny_reg <= ny_w[19:0];
        end
        case (post_sel_reg)
            ksub_pkg::DP_MUL_QX: qx_reg   <= div_q_wide[18:0];
            ksub_pkg::DP_MUL_QY: qy_reg   <= div_q_wide[18:0];
            ksub_pkg::DP_MUL_OX: offx_reg <= rnd_prod[33:16];
            ksub_pkg::DP_MUL_OY: offy_reg <= rnd_prod[33:16];
            default: ;
        endcase
        if (op == ksub_pkg::DP_VERTEX) begin
            v0_reg <= '{x: ax_x.v0, y: ax_y.v0};
            v1_reg <= '{x: ax_x.v1, y: ax_y.v1};
            pk_reg <= '{x: ax_x.pk, y: ax_y.pk};
        end
    end

    // Tag of the product in flight, so it lands in the right register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            post_sel_reg <= ksub_pkg::DP_NOP;
        end else begin
            post_sel_reg <= op;
        end
    end

    // Sibling stack and current segment.
    always_ff @(posedge aclk) begin
        case (op)
            ksub_pkg::DP_LOAD_IN: begin
                cur_reg.a.x <= s_tdata[17:0];
                cur_reg.a.y <= s_tdata[35:18];
                cur_reg.b.x <= s_tdata[53:36];
                cur_reg.b.y <= s_tdata[71:54];
                lvl_reg     <= '0;
            end
            ksub_pkg::DP_PUSH_HI: begin
                stack_mem[sp_reg[ksub_pkg::STACK_IDX_W-1:0]] <=
                    '{seg: '{a: v1_reg, b: cur_reg.b}, lvl: lvl_child};
            end
            ksub_pkg::DP_PUSH_MID: begin
                stack_mem[sp_reg[ksub_pkg::STACK_IDX_W-1:0]] <=
                    '{seg: '{a: pk_reg, b: v1_reg}, lvl: lvl_child};
            end
            ksub_pkg::DP_PUSH_LO: begin
                stack_mem[sp_reg[ksub_pkg::STACK_IDX_W-1:0]] <=
                    '{seg: '{a: v0_reg, b: pk_reg}, lvl: lvl_child};
                cur_reg.b <= v0_reg;
                lvl_reg   <= lvl_child;
            end
            ksub_pkg::DP_EMIT: begin
                if (sp_reg != '0) begin
                    cur_reg <= stack_mem[sp_top[ksub_pkg::STACK_IDX_W-1:0]].seg;
                    lvl_reg <= stack_mem[sp_top[ksub_pkg::STACK_IDX_W-1:0]].lvl;
                end
            end
            default: ;
        endcase
    end

    // Stack pointer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sp_reg <= '0;
        end else begin
            case (op)
                ksub_pkg::DP_LOAD_IN:  sp_reg <= '0;
                ksub_pkg::DP_PUSH_HI,
                ksub_pkg::DP_PUSH_MID,
                ksub_pkg::DP_PUSH_LO:  sp_reg <= sp_reg + 1'b1;
                ksub_pkg::DP_EMIT: begin
                    if (sp_reg != '0) begin
                        sp_reg <= sp_top;
                    end
                end
                default: ;
            endcase
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (op == ksub_pkg::DP_EMIT) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (op == ksub_pkg::DP_EMIT) begin
            out_seg_reg  <= cur_reg;
            out_last_reg <= (sp_reg == '0);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {out_seg_reg.b.y, out_seg_reg.b.x, out_seg_reg.a.y, out_seg_reg.a.x};

    assign status.leaf        = (lvl_reg == depth_reg);
    assign status.stack_empty = (sp_reg == '0);
    assign status.out_free    = !out_valid_reg || m_tready;

endmodule

[hdl/koch_segment_subdivider_core.sv]
// Operation: each request is walked depth first. A segment above the set depth is split through
// the shared multiplier (differences, two quotients, two peak offsets, vertices, three sibling
// pushes); a leaf segment is emitted into the output register, and output stalls hold the walk.
// A new request is accepted only after the last segment of the previous one has been emitted.
// Reset: synchronous, active low; clears the controller, stack pointer and output valid,
// and sets the depth register to 3.
`timescale 1ns / 1ps

module koch_segment_subdivider_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_wr_data,  // subdivision_depth
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,      // start_x, start_y, end_x, end_y
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,      // seg_start_x, seg_start_y, seg_end_x, seg_end_y
    output logic        m_tlast       // last_segment
);

    ksub_pkg::dp_op_t     op;
    ksub_pkg::dp_status_t status;

    ksub_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .op       (op)
    );

    ksub_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .op          (op),
        .status      (status),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .m_tdata     (m_tdata),
        .m_tvalid    (m_tvalid),
        .m_tlast     (m_tlast),
        .m_tready    (m_tready)
    );

    // A new request starts with an empty sibling stack.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |-> status.stack_empty)
        else $error("request accepted with pending siblings");

    // A segment is only emitted when the output register can take it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (op == ksub_pkg::DP_EMIT) |-> status.out_free)
        else $error("segment emitted over a held result");

    // The final segment flags tlast and returns the block to accepting requests.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (op == ksub_pkg::DP_EMIT && status.stack_empty) |=> (s_tready && m_tvalid && m_tlast))
        else $error("final segment did not close the request");

    // Intermediate segments never carry tlast.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (op == ksub_pkg::DP_EMIT && !status.stack_empty) |=> (!m_tlast && !s_tready))
        else $error("intermediate segment flagged as last");

endmodule

[tb/sv/koch_segment_checker.sv]
// Checker for the Koch segment subdivider: tracks depth, predicts segments and compares them.
`timescale 1ns / 1ps
module koch_segment_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_wr_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [71:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [71:0] m_tdata,
    input  logic        m_tlast,
    output int          fail_count,
    output int          pending_count
);

    // sqrt(3)/6 in Q0.16 and the half-LSB used to round the peak offset.
    localparam longint PEAK_SCALE = 18919;
    localparam longint HALF_Q16   = 32768;
    localparam longint ONE_Q16    = 65536;
    localparam longint XY_HI      = 131071;
    localparam longint XY_LO      = -131072;

    typedef struct packed {
        ksub_pkg::coord_t start_x;
        ksub_pkg::coord_t start_y;
        ksub_pkg::coord_t end_x;
        ksub_pkg::coord_t end_y;
        logic             last;
    } segment_result_t;

    segment_result_t expected_segments[$];
    logic [1:0]      depth_setting;
    int              mismatch_total;

    initial begin
        depth_setting  = 2'd3;
        mismatch_total = 0;
    end

    function automatic longint floor_div(input longint n, input longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && ((n < 0) != (d < 0))) begin
            q = q - 1;
        end
        return q;
    endfunction

    function automatic ksub_pkg::coord_t clamp_coord(input longint v);
        if (v > XY_HI) begin
            return ksub_pkg::coord_t'(XY_HI);
        end else if (v < XY_LO) begin
            return ksub_pkg::coord_t'(XY_LO);
        end
        return ksub_pkg::coord_t'(v);
    endfunction

    // Split every segment into its four Koch children once per level. Expanding in place
    // keeps the children in order, which gives the same leaf order as a depth-first walk.
    function automatic void expand_segment(input ksub_pkg::seg_t root, input int levels);
        ksub_pkg::seg_t   frontier[$];
        ksub_pkg::seg_t   children[$];
        ksub_pkg::seg_t   s;
        ksub_pkg::point_t v0;
        ksub_pkg::point_t v1;
        ksub_pkg::point_t peak;
        longint           ax, ay, bx, by, dx, dy;
        segment_result_t  r;
        frontier.push_back(root);
        for (int lvl = 0; lvl < levels; lvl++) begin
            children.delete();
            foreach (frontier[i]) begin
                s  = frontier[i];
                ax = longint'(s.a.x);
                ay = longint'(s.a.y);
                bx = longint'(s.b.x);
                by = longint'(s.b.y);
                dx = bx - ax;
                dy = by - ay;
                v0.x   = clamp_coord(ax + floor_div(dx, 3));
                v0.y   = clamp_coord(ay + floor_div(dy, 3));
                v1.x   = clamp_coord(ax + floor_div(2 * dx, 3));
                v1.y   = clamp_coord(ay + floor_div(2 * dy, 3));
                peak.x = clamp_coord(floor_div(ax + bx, 2)
                                     + floor_div(-PEAK_SCALE * dy + HALF_Q16, ONE_Q16));
                peak.y = clamp_coord(floor_div(ay + by, 2)
                                     + floor_div(PEAK_SCALE * dx + HALF_Q16, ONE_Q16));
                children.push_back('{s.a, v0});
                children.push_back('{v0, peak});
                children.push_back('{peak, v1});
                children.push_back('{v1, s.b});
            end
            frontier = children;
        end
        foreach (frontier[i]) begin
            r.start_x = frontier[i].a.x;
            r.start_y = frontier[i].a.y;
            r.end_x   = frontier[i].b.x;
            r.end_y   = frontier[i].b.y;
            r.last    = (i == frontier.size() - 1);
            expected_segments.push_back(r);
        end
    endfunction

    function automatic void check_field(input string field, input longint want,
                                        input longint got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", field, want, got);
            mismatch_total++;
        end
    endfunction

    // Track the depth register, predict on each accepted request, compare each result.
    always @(posedge aclk) begin
        ksub_pkg::seg_t  request;
        segment_result_t got;
        segment_result_t want;
        if (!aresetn) begin
            depth_setting = 2'd3;
            expected_segments.delete();
        end else begin
            if (cfg_wr_en) begin
                depth_setting = cfg_wr_data;
            end
            if (s_tvalid && s_tready) begin
                request.a.x = s_tdata[17:0];
                request.a.y = s_tdata[35:18];
                request.b.x = s_tdata[53:36];
                request.b.y = s_tdata[71:54];
                expand_segment(request, int'(depth_setting));
            end
            if (m_tvalid && m_tready) begin
                got.start_x = m_tdata[17:0];
                got.start_y = m_tdata[35:18];
                got.end_x   = m_tdata[53:36];
                got.end_y   = m_tdata[71:54];
                got.last    = m_tlast;
                if (expected_segments.size() == 0) begin
                    $error("unexpected result segment (%0d,%0d)-(%0d,%0d) last %0d",
                           got.start_x, got.start_y, got.end_x, got.end_y, got.last);
                    mismatch_total++;
                end else begin
                    want = expected_segments.pop_front();
                    check_field("seg_start_x", longint'(want.start_x),
                                longint'(got.start_x));
                    check_field("seg_start_y", longint'(want.start_y),
                                longint'(got.start_y));
                    check_field("seg_end_x", longint'(want.end_x), longint'(got.end_x));
                    check_field("seg_end_y", longint'(want.end_y), longint'(got.end_y));
                    check_field("last_segment", longint'(want.last), longint'(got.last));
                end
            end
        end
        fail_count    <= mismatch_total;
        pending_count <= expected_segments.size();
    end

endmodule

[tb/sv/tb_koch_segment_subdivider_core.sv]
// Testbench top for the Koch segment subdivider: request stimulus, back-pressure and verdict.
`timescale 1ns / 1ps
module tb_koch_segment_subdivider_core;

    localparam int XY_MAX          = 131071;
    localparam int XY_MIN          = -131072;
    localparam int ITEMS_PER_PHASE = 55;
    localparam int SETTLE_CYCLES   = 8;
    localparam int CYCLE_LIMIT     = 2_000_000;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_PERIODIC
    } rx_mode_t;

    typedef struct packed {
        logic [1:0]     level;
        ksub_pkg::seg_t seg;
    } directed_request_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [1:0]  cfg_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic        m_tlast;
    int          fail_count;
    int          pending_count;

    int                burst_left  = 0;
    int                cycle_count = 0;
    int                rx_left     = 0;
    int                rx_phase    = 0;
    rx_mode_t          rx_mode     = RX_OPEN;
    logic [1:0]        current_depth;
    directed_request_t directed[$];
    logic [1:0]        phase_depths[8] = '{2'd2, 2'd0, 2'd3, 2'd1, 2'd3, 2'd0, 2'd2, 2'd1};

    koch_segment_subdivider_core u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    koch_segment_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // Free-running clock.
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Run timeout.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("koch_segment_subdivider_core verification failed");
            $finish;
        end
    end

    // Result back-pressure: stretches of always-ready, coin-flip, sparse and periodic stalls.
    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_left = $urandom_range(8, 80);
        end
        rx_left--;
        rx_phase++;
        case (rx_mode)
            RX_OPEN: begin
                m_tready <= 1'b1;
            end
            RX_COIN: begin
                m_tready <= 1'($urandom_range(0, 1));
            end
            RX_SPARSE: begin
                m_tready <= ($urandom_range(0, 3) == 0);
            end
            default: begin
                m_tready <= (rx_phase % 5 != 0);
            end
        endcase
    end

    function automatic ksub_pkg::seg_t make_seg(input ksub_pkg::coord_t ax,
                                                input ksub_pkg::coord_t ay,
                                                input ksub_pkg::coord_t bx,
                                                input ksub_pkg::coord_t by);
        ksub_pkg::seg_t s;
        s.a.x = ax;
        s.a.y = ay;
        s.b.x = bx;
        s.b.y = by;
        return s;
    endfunction

    function automatic ksub_pkg::coord_t extreme_coord();
        case ($urandom_range(0, 4))
            0: return ksub_pkg::coord_t'(XY_MIN);
            1: return ksub_pkg::coord_t'(XY_MAX);
            2: return ksub_pkg::coord_t'(0);
            3: return ksub_pkg::coord_t'(-1);
            default: return ksub_pkg::coord_t'($urandom);
        endcase
    endfunction

    // A coordinate within a small window of the base, kept in range.
    function automatic ksub_pkg::coord_t near_coord(input ksub_pkg::coord_t base);
        int v;
        v = int'(base) + int'($urandom_range(0, 128)) - 64;
        if (v > XY_MAX) begin
            v = XY_MAX;
        end else if (v < XY_MIN) begin
            v = XY_MIN;
        end
        return ksub_pkg::coord_t'(v);
    endfunction

    // Mostly full-range segments, plus short segments and corner-heavy ones.
    function automatic ksub_pkg::seg_t random_segment();
        ksub_pkg::seg_t s;
        int             pick;
        pick = $urandom_range(0, 19);
        if (pick < 12) begin
            s = make_seg(ksub_pkg::coord_t'($urandom), ksub_pkg::coord_t'($urandom),
                         ksub_pkg::coord_t'($urandom), ksub_pkg::coord_t'($urandom));
        end else if (pick < 17) begin
            s.a.x = ksub_pkg::coord_t'($urandom);
            s.a.y = ksub_pkg::coord_t'($urandom);
            s.b.x = near_coord(s.a.x);
            s.b.y = near_coord(s.a.y);
        end else begin
            s = make_seg(extreme_coord(), extreme_coord(), extreme_coord(), extreme_coord());
        end
        return s;
    endfunction

    task automatic add_directed(input logic [1:0] level, input int ax, input int ay,
                                input int bx, input int by);
        directed.push_back('{level, make_seg(ksub_pkg::coord_t'(ax), ksub_pkg::coord_t'(ay),
                                             ksub_pkg::coord_t'(bx), ksub_pkg::coord_t'(by))});
    endtask

    // Send one request; the sender works in bursts separated by idle gaps.
    task automatic send_segment(input ksub_pkg::seg_t seg);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 40);
            repeat (gap) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {seg.b.y, seg.b.x, seg.a.y, seg.a.x};
        do @(posedge aclk); while (!s_tready);
        burst_left--;
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
        end
    endtask

    // Stop sending and wait until every predicted result has come back.
    task automatic close_phase();
        if (burst_left != 0) begin
            s_tvalid   <= 1'b0;
            burst_left = 0;
        end
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_depth(input logic [1:0] level);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= level;
        @(posedge aclk);
        cfg_wr_en     <= 1'b0;
        current_depth = level;
    endtask

    // Main stimulus: directed corner cases first, then random phases at varying depths.
    initial begin
        aresetn     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= 2'd0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        current_depth = 2'd3;

        // Reset depth: zero length, full diagonal, peak driven past the x limit.
        add_directed(2'd3, 0, 0, 0, 0);
        add_directed(2'd3, XY_MIN, XY_MIN, XY_MAX, XY_MAX);
        add_directed(2'd3, XY_MAX, XY_MAX, XY_MAX, XY_MIN);
        // One level: corners, axis-aligned extremes, rounding ties and tiny steps.
        add_directed(2'd1, XY_MAX, XY_MAX, XY_MAX, XY_MAX);
        add_directed(2'd1, XY_MIN, XY_MIN, XY_MIN, XY_MIN);
        add_directed(2'd1, XY_MIN, 0, XY_MAX, 0);
        add_directed(2'd1, XY_MAX, 0, XY_MIN, 0);
        add_directed(2'd1, XY_MIN, XY_MIN, XY_MAX, XY_MIN);
        add_directed(2'd1, XY_MAX, XY_MIN, XY_MIN, XY_MIN);
        add_directed(2'd1, 0, XY_MIN, 0, XY_MAX);
        add_directed(2'd1, 0, 0, 32768, -32768);
        add_directed(2'd1, 0, 0, -32768, 32768);
        add_directed(2'd1, 0, 0, 1, 0);
        add_directed(2'd1, 0, 0, -1, -1);
        add_directed(2'd1, 5, 7, 7, 5);
        add_directed(2'd1, 0, 0, 2, -2);
        add_directed(2'd1, -1, -1, 0, 0);
        add_directed(2'd1, XY_MAX, XY_MIN, XY_MIN, XY_MAX);
        // No subdivision: the request passes straight through.
        add_directed(2'd0, XY_MIN, XY_MAX, XY_MAX, XY_MIN);
        add_directed(2'd0, -1, 0, 0, -1);
        add_directed(2'd0, 123, -456, -789, 1011);
        // Two levels.
        add_directed(2'd2, XY_MIN, XY_MIN, XY_MAX, XY_MAX);
        add_directed(2'd2, 0, 0, 0, 0);

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed[i]) begin
            if (directed[i].level != current_depth) begin
                close_phase();
                set_depth(directed[i].level);
            end
            send_segment(directed[i].seg);
        end

        foreach (phase_depths[p]) begin
            close_phase();
            set_depth(phase_depths[p]);
            repeat (ITEMS_PER_PHASE) send_segment(random_segment());
        end

        close_phase();
        if (fail_count == 0 && pending_count == 0) begin
            $display("koch_segment_subdivider_core verification clean");
        end else begin
            $display("koch_segment_subdivider_core verification failed");
        end
        $finish;
    end

endmodule
